// ===== rtl/core/config_statement_lexer_macros.svh =====
// Assertion helpers for the checker file.
`ifndef CONFIG_STATEMENT_LEXER_MACROS_SVH
`define CONFIG_STATEMENT_LEXER_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define CSL_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("config_statement_lexer: assertion failed");

// Shorthand for the block clock and reset names.
`define CSL_ASSERT(label, prop) \
  `CSL_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== rtl/core/csl_pkg.sv =====
`default_nettype none

package csl_pkg;

  localparam int MAX_STATEMENT_DEF = 256;

  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_UNEXPECTED = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_NL_STRING  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_SKIP   = 3'b010,
    MODE_STRING = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        is_end;
    status_e     status;
    logic [15:0] line_number;
  } res_t;

  // Results of one processed item: count (0..2) and the two slots.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csl_in_if.sv =====
`default_nettype none

interface csl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/csl_out_if.sv =====
`default_nettype none

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        is_end;
  logic [2:0]  status;
  logic [15:0] line_number;

  modport source (output valid, output out_char, output is_end, output status,
                  output line_number, input ready);
  modport sink   (input valid, input out_char, input is_end, input status,
                  input line_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/config_statement_lexer.sv =====
// Statement lexer for configuration text. Each input item is one source byte
// (kind 0) or an end-of-input mark (kind 1); each result item is either one
// normalized statement character or a statement end carrying a status
// (ok, complete, unexpected end, too long, newline in string) and the current
// line number. One input item is taken per cycle: the item is registered,
// the lexer state updates when it is processed, and its zero, one or two
// results go into a four-entry result queue. Sustained rate is one item per
// cycle while results are drained one per cycle; an item that yields two
// results (a held-back space plus a character) writes both entries at once,
// and the input stalls only when the result queue has fewer than two free
// entries. Each accepted byte is registered, then its results are queued.
`default_nettype none

module config_statement_lexer #(
  parameter int MAX_STATEMENT = csl_pkg::MAX_STATEMENT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csl_in_if.sink    src_i,
  csl_out_if.source res_o
);

  csl_pkg::push_t push;   // results of the item processed this cycle
  logic           room;   // queue can take two more results

  // Byte register and lexer state; drop nothing, stall when the queue lacks room for two.
  csl_lexer #(
    .MAX_STATEMENT(MAX_STATEMENT)
  ) u_lexer (
    .clk_i,
    .rst_ni,
    .src_i,
    .room_i (room),
    .push_o (push)
  );

  // Hold results until the downstream side takes them.
  csl_res_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .room_o (room),
    .res_o
  );

endmodule

`default_nettype wire

// ===== rtl/core/csl_lexer.sv =====
`default_nettype none

module csl_lexer #(
  parameter int MAX_STATEMENT = csl_pkg::MAX_STATEMENT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  csl_in_if.sink          src_i,
  input  wire logic       room_i,
  output csl_pkg::push_t  push_o
);

  localparam int CW = $clog2(MAX_STATEMENT);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_STATEMENT - 1);

  // Input register.
  logic       s1_valid_q;
  logic       s1_kind_q;
  logic [7:0] s1_byte_q;
  logic       fire;

  assign fire        = s1_valid_q && room_i;
  assign src_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (src_i.ready) begin
      s1_valid_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_i.ready && src_i.valid) begin
      s1_kind_q <= src_i.kind;
      s1_byte_q <= src_i.in_byte;
    end
  end

  // Lexer state.
  csl_pkg::mode_e mode_q, mode_d;
  logic           esc_q, esc_d;
  logic           insp_q, insp_d;
  logic           spend_q, spend_d;
  logic           ls_q, ls_d;
  logic           qd_q, qd_d;
  logic [CW-1:0]  cc_q, cc_d;
  logic [15:0]    lc_q, lc_d;

  csl_pkg::push_t push;
  logic           do_end;
  csl_pkg::status_e end_st;
  logic [15:0]    lc_bump;

  assign lc_bump = (lc_q != csl_pkg::LINE_MAX) ? lc_q + 16'd1 : lc_q;

  always_comb begin
    mode_d  = mode_q;
    esc_d   = esc_q;
    insp_d  = insp_q;
    spend_d = spend_q;
    ls_d    = ls_q;
    qd_d    = qd_q;
    cc_d    = cc_q;
    lc_d    = lc_q;
    do_end  = 1'b0;
    end_st  = csl_pkg::ST_OK;
    push    = '0;
    push.r0.line_number = lc_q;
    push.r1.line_number = lc_q;

    if (s1_kind_q) begin
      do_end = 1'b1;
      if (mode_q == csl_pkg::MODE_STRING || (mode_q == csl_pkg::MODE_SKIP && esc_q)) begin
        end_st = csl_pkg::ST_UNEXPECTED;
      end else if (cc_q != '0) begin
        end_st = csl_pkg::ST_UNEXPECTED;
      end else begin
        end_st = csl_pkg::ST_COMPLETE;
      end
    end else begin
      ls_d = (s1_byte_q == csl_pkg::CH_LF);
      unique case (mode_q)
        csl_pkg::MODE_SKIP: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (s1_byte_q == csl_pkg::CH_BSLASH) begin
            esc_d = 1'b1;
          end else if (s1_byte_q == csl_pkg::CH_LF) begin
            lc_d   = lc_bump;
            mode_d = csl_pkg::MODE_NORMAL;
          end
        end
        csl_pkg::MODE_STRING: begin
          if (cc_q >= LIMIT) begin
            do_end = 1'b1;
            end_st = csl_pkg::ST_TOO_LONG;
          end else if (s1_byte_q == csl_pkg::CH_LF) begin
            do_end = 1'b1;
            end_st = csl_pkg::ST_NL_STRING;
          end else begin
            push.n          = 2'd1;
            push.r0.out_char = s1_byte_q;
            cc_d            = cc_q + 1'b1;
            if (esc_q) begin
              esc_d = 1'b0;
            end else if (s1_byte_q == csl_pkg::CH_BSLASH) begin
              esc_d = 1'b1;
            end else if (s1_byte_q == (qd_q ? csl_pkg::CH_DQUOTE : csl_pkg::CH_SQUOTE)) begin
              mode_d = csl_pkg::MODE_NORMAL;
            end
          end
        end
        default: begin
          // Normal mode; a stray mode code behaves the same.
          mode_d = csl_pkg::MODE_NORMAL;
          if (cc_q >= LIMIT) begin
            do_end = 1'b1;
            end_st = csl_pkg::ST_TOO_LONG;
          end else if (ls_q && s1_byte_q == csl_pkg::CH_HASH) begin
            mode_d = csl_pkg::MODE_SKIP;
            esc_d  = 1'b0;
          end else begin
            if (s1_byte_q == csl_pkg::CH_LF) begin
              lc_d = lc_bump;
            end
            if (csl_pkg::is_blank(s1_byte_q)) begin
              if (!insp_q) begin
                cc_d    = cc_q + 1'b1;
                spend_d = 1'b1;
                insp_d  = 1'b1;
              end
            end else if (s1_byte_q == csl_pkg::CH_SEMI) begin
              do_end = 1'b1;
              end_st = csl_pkg::ST_OK;
            end else begin
              insp_d = 1'b0;
              cc_d   = cc_q + 1'b1;
              if (spend_q) begin
                spend_d          = 1'b0;
                push.n           = 2'd2;
                push.r0.out_char = csl_pkg::CH_SPACE;
                push.r1.out_char = s1_byte_q;
              end else begin
                push.n           = 2'd1;
                push.r0.out_char = s1_byte_q;
              end
              if (s1_byte_q == csl_pkg::CH_DQUOTE || s1_byte_q == csl_pkg::CH_SQUOTE) begin
                mode_d = csl_pkg::MODE_STRING;
                qd_d   = (s1_byte_q == csl_pkg::CH_DQUOTE);
                esc_d  = 1'b0;
              end
            end
          end
        end
      endcase
    end

    if (do_end) begin
      push.n         = 2'd1;
      push.r0.is_end = 1'b1;
      push.r0.status = end_st;
      mode_d  = csl_pkg::MODE_NORMAL;
      esc_d   = 1'b0;
      insp_d  = 1'b1;
      spend_d = 1'b0;
      qd_d    = 1'b0;
      cc_d    = '0;
    end

    if (!fire) begin
      push.n = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= csl_pkg::MODE_NORMAL;
      esc_q   <= 1'b0;
      insp_q  <= 1'b1;
      spend_q <= 1'b0;
      ls_q    <= 1'b1;
      qd_q    <= 1'b0;
      cc_q    <= '0;
      lc_q    <= 16'd1;
    end else if (fire) begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      insp_q  <= insp_d;
      spend_q <= spend_d;
      ls_q    <= ls_d;
      qd_q    <= qd_d;
      cc_q    <= cc_d;
      lc_q    <= lc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/csl_res_fifo.sv =====
`default_nettype none

module csl_res_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire csl_pkg::push_t push_i,
  output logic                room_o,
  csl_out_if.source           res_o
);

  csl_pkg::res_t mem_q [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    cnt_q, cnt_d;
  logic          pop;
  csl_pkg::res_t head;

  assign head   = mem_q[rd_q];
  assign pop    = res_o.valid && res_o.ready;
  assign room_o = (cnt_q <= 3'd2);

  assign res_o.valid       = (cnt_q != 3'd0);
  assign res_o.out_char    = head.out_char;
  assign res_o.is_end      = head.is_end;
  assign res_o.status      = head.status;
  assign res_o.line_number = head.line_number;

  assign cnt_d = cnt_q + {1'b0, push_i.n} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.n;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/csl_checker.sv =====
`default_nettype none
`include "config_statement_lexer_macros.svh"

module csl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [7:0]  res_char_i,
  input wire logic        res_end_i,
  input wire logic [2:0]  res_status_i,
  input wire logic [15:0] res_line_i
);

  `CSL_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_char_i) && $stable(res_end_i) && $stable(res_status_i) && $stable(res_line_i))
  `CSL_ASSERT(a_char_ok, res_valid_i && !res_end_i |-> res_status_i == csl_pkg::ST_OK)
  `CSL_ASSERT(a_end_form, res_valid_i && res_end_i |-> res_char_i == 8'd0 && res_status_i <= csl_pkg::ST_NL_STRING)
  `CSL_ASSERT(a_line_seq, res_valid_i && res_ready_i ##1 res_valid_i |-> res_line_i >= $past(res_line_i) && res_line_i != 16'd0)

endmodule

bind config_statement_lexer csl_checker u_csl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_char_i   (res_o.out_char),
  .res_end_i    (res_o.is_end),
  .res_status_i (res_o.status),
  .res_line_i   (res_o.line_number)
);

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
  import csl_pkg::*;

  localparam int STMT_LIMIT  = MAX_STATEMENT_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 8;
  localparam int MAX_REPORTS = 10;

  // Statement predictor plus the queue of statement results still owed by the lexer.
  class lexer_scoreboard;
    mode_e           mode;
    bit              esc;
    bit              in_space;
    bit              space_pend;
    bit              line_start;
    bit              dquote;
    int unsigned     char_cnt;
    logic [15:0]     line_cnt;
    res_t            pending[$];
    int              errors;

    function void clear_stmt();
      mode       = MODE_NORMAL;
      esc        = 1'b0;
      in_space   = 1'b1;
      space_pend = 1'b0;
      dquote     = 1'b0;
      char_cnt   = 0;
    endfunction

    function void reset_state();
      clear_stmt();
      line_start = 1'b1;
      line_cnt   = 16'd1;
      errors     = 0;
      pending.delete();
    endfunction

    function void bump_line();
      if (line_cnt != LINE_MAX) line_cnt++;
    endfunction

    function bit blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void push_char(logic [7:0] c);
      pending.push_back('{out_char: c, is_end: 1'b0, status: ST_OK, line_number: line_cnt});
    endfunction

    function void push_end(status_e st);
      pending.push_back('{out_char: 8'h00, is_end: 1'b1, status: st, line_number: line_cnt});
      clear_stmt();
    endfunction

    // Advance the predicted lexer by one accepted item.
    function void note_input(logic k, logic [7:0] c);
      bit          was_ls;
      logic [7:0]  delim;
      if (k) begin
        if (mode == MODE_STRING || (mode == MODE_SKIP && esc)) push_end(ST_UNEXPECTED);
        else if (char_cnt != 0) push_end(ST_UNEXPECTED);
        else push_end(ST_COMPLETE);
        return;
      end
      was_ls     = line_start;
      line_start = (c == CH_LF);
      if (mode == MODE_SKIP) begin
        if (esc) esc = 1'b0;
        else if (c == CH_BSLASH) esc = 1'b1;
        else if (c == CH_LF) begin
          bump_line();
          mode = MODE_NORMAL;
        end
        return;
      end
      if (mode == MODE_STRING) begin
        delim = dquote ? CH_DQUOTE : CH_SQUOTE;
        if (char_cnt >= STMT_LIMIT - 1) begin
          push_end(ST_TOO_LONG);
          return;
        end
        if (c == CH_LF) begin
          push_end(ST_NL_STRING);
          return;
        end
        push_char(c);
        char_cnt++;
        if (esc) esc = 1'b0;
        else if (c == CH_BSLASH) esc = 1'b1;
        else if (c == delim) mode = MODE_NORMAL;
        return;
      end
      mode = MODE_NORMAL;
      if (char_cnt >= STMT_LIMIT - 1) begin
        push_end(ST_TOO_LONG);
        return;
      end
      if (was_ls && c == CH_HASH) begin
        mode = MODE_SKIP;
        esc  = 1'b0;
        return;
      end
      if (c == CH_LF) bump_line();
      if (blank(c)) begin
        if (!in_space) begin
          char_cnt++;
          space_pend = 1'b1;
          in_space   = 1'b1;
        end
        return;
      end
      in_space = 1'b0;
      if (c == CH_SEMI) begin
        push_end(ST_OK);
        return;
      end
      if (space_pend) begin
        push_char(CH_SPACE);
        space_pend = 1'b0;
      end
      push_char(c);
      char_cnt++;
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        mode   = MODE_STRING;
        dquote = (c == CH_DQUOTE);
        esc    = 1'b0;
      end
    endfunction

    // Compare one accepted result item against the oldest prediction.
    function void check_result(logic [7:0] ch, logic e, logic [2:0] st, logic [15:0] ln);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: char %02h end %0d status %0d line %0d",
                   ch, e, st, ln);
        return;
      end
      want = pending.pop_front();
      if (want.out_char !== ch || want.is_end !== e || want.status !== st ||
          want.line_number !== ln) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result mismatch: expected char %02h end %0d status %0d line %0d, got char %02h end %0d status %0d line %0d",
                   want.out_char, want.is_end, want.status, want.line_number,
                   ch, e, st, ln);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  csl_in_if  in_ch ();
  csl_out_if out_ch ();

  config_statement_lexer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .src_i  (in_ch),
    .res_o  (out_ch)
  );

  lexer_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     items_sent;
  int unsigned     cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sink side: sample a result on every handshake, then roll the next ready.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_char, out_ch.is_end, out_ch.status, out_ch.line_number);
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until accepted.
  // Valid stays high across back-to-back items, so it gets one assignment per edge.
  task automatic send_item(input logic k, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(k, b);
    items_sent++;
  endtask

  // Printable, non-blank byte that neither ends a statement nor opens a string.
  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (c == CH_SEMI || c == CH_DQUOTE || c == CH_SQUOTE)
      c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] c;
    c = 8'($urandom_range(8, 13));
    if (c == 8'd8) c = CH_SPACE;
    return c;
  endfunction

  // Run a statement past the length limit; outside a string, spaces count once per run.
  task automatic long_run(input bit in_str);
    logic [7:0] c;
    if (in_str) send_item(1'b0, CH_DQUOTE);
    repeat (STMT_LIMIT + 2) begin
      c = ($urandom_range(0, 4) == 0) ? CH_SPACE : pick_word_char();
      send_item(1'b0, c);
    end
    send_item(1'b0, CH_SEMI);
  endtask

  // Build one statement from random words, blank runs, strings, directive lines
  // and single random bytes, then close it one of several ways.
  task automatic emit_statement();
    int unsigned pieces;
    int unsigned sel;
    logic [7:0]  delim;
    logic [7:0]  c;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
        repeat ($urandom_range(1, 5)) send_item(1'b0, pick_word_char());
      end else if (sel <= 5) begin
        repeat ($urandom_range(1, 3)) send_item(1'b0, pick_blank());
      end else if (sel <= 7) begin
        delim = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_item(1'b0, delim);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(1'b0, CH_BSLASH);
            c = 8'($urandom_range(0, 255));
            if (c == CH_LF) c = delim;
            send_item(1'b0, c);
          end else begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_LF || c == delim || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
            send_item(1'b0, c);
          end
        end
        send_item(1'b0, delim);
      end else if (sel == 8) begin
        // directive line, sometimes continued with a backslash
        send_item(1'b0, CH_LF);
        send_item(1'b0, CH_HASH);
        repeat ($urandom_range(0, 4)) send_item(1'b0, pick_word_char());
        if ($urandom_range(0, 2) == 0) begin
          send_item(1'b0, CH_BSLASH);
          send_item(1'b0, CH_LF);
          repeat ($urandom_range(0, 3)) send_item(1'b0, pick_word_char());
        end
        send_item(1'b0, CH_LF);
      end else begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      send_item(1'b0, CH_SEMI);
    end else if (sel < 83) begin
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (sel < 90) begin
      send_item(1'b0, CH_SQUOTE);
      send_item(1'b0, pick_word_char());
      send_item(1'b0, CH_LF);
    end else if (sel < 94) begin
      send_item(1'b0, CH_DQUOTE);
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (sel < 98) begin
      // end of input right after a backslash in a directive line
      send_item(1'b0, CH_LF);
      send_item(1'b0, CH_HASH);
      send_item(1'b0, CH_BSLASH);
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      // end of input right after a trailing blank
      send_item(1'b0, CH_SPACE);
      send_item(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  int unsigned idle_plan[4]  = '{0, 86, 0, 28};
  int unsigned stall_plan[4] = '{0, 0, 86, 28};
  int unsigned target;

  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    cycles         = 0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = 1'b0;
    in_ch.in_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: directive with continuation at reset line start.
    send_item(1'b0, CH_HASH);
    send_item(1'b0, 8'h78);
    send_item(1'b0, CH_BSLASH);
    send_item(1'b0, CH_LF);
    send_item(1'b0, 8'h79);
    send_item(1'b0, CH_LF);
    // Leading blanks dropped, mixed run collapsed, top byte value passed.
    send_item(1'b0, CH_SPACE);
    send_item(1'b0, 8'h61);
    send_item(1'b0, CH_TAB);
    send_item(1'b0, CH_SPACE);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_SEMI);
    // String with an escaped quote, a kept space and a zero byte after it.
    send_item(1'b0, CH_DQUOTE);
    send_item(1'b0, CH_BSLASH);
    send_item(1'b0, CH_DQUOTE);
    send_item(1'b0, CH_SPACE);
    send_item(1'b0, CH_DQUOTE);
    send_item(1'b0, 8'h00);
    send_item(1'b0, CH_SEMI);
    // Newline inside a string.
    send_item(1'b0, CH_SQUOTE);
    send_item(1'b0, 8'h78);
    send_item(1'b0, CH_LF);
    // End of input with nothing gathered, then with a partial statement.
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h7A);
    send_item(1'b1, 8'hFF);

    // Random statements across the idle/stall plans; the idle-heavy and the
    // stall-heavy phases also carry the over-long statements, plain and inside a string.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 1) long_run(1'b0);
      if (p == 2) long_run(1'b1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 6))
            send_item($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        end else begin
          emit_statement();
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then keep clocking to catch stray results.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
